// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int POS_BITS_DEF = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] COMMENT_RESET = 8'd35;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef enum logic [4:0] {
		KIND_IDENT, KIND_INT, KIND_ASSIGN, KIND_EQ, KIND_ADD, KIND_INC, KIND_SUB,
		KIND_DEC, KIND_NE, KIND_LE, KIND_SHL, KIND_ROL, KIND_LT, KIND_GE, KIND_SHR,
		KIND_ROR, KIND_GT, KIND_LAND, KIND_AND, KIND_LOR, KIND_OR, KIND_MUL,
		KIND_DIV, KIND_MOD, KIND_XOR, KIND_UNKNOWN
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} tok_t;

endpackage

// ----- rtl/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer, one source byte per item.
// An accepted item is registered, then its tokens enter the token queue.
// Throughput: one item per cycle when not stalled; an item may yield two tokens.
// Reset: asynchronous, clears the scan state, position, token queue and comment byte ('#').
// ----------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  token_kind,
	output logic [63:0] literal_value,
	output logic [15:0] start_pos,
	output logic [15:0] token_length,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  comment_char
);

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_DEC, M_OCT, M_HEX, M_COMMENT,
		M_EQ, M_PLUS, M_MINUS, M_BANG, M_LT, M_LT2, M_GT, M_GT2, M_AMP, M_BAR
	} mode_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic [15:0] bump(input logic [15:0] n);
		return (n == LEN_MAX) ? n : n + 16'd1;
	endfunction

	function automatic tok_t make_tok(input kind_t k, input logic [63:0] v,
			input logic [15:0] s, input logic [15:0] len);
		tok_t t;
		t.kind = k;
		t.value = v;
		t.start = s;
		t.length = len;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic logic has_pending(input mode_t m);
		return m != M_IDLE && m != M_COMMENT;
	endfunction

	function automatic tok_t flush_tok(input mode_t m, input logic [63:0] a,
			input logic [POS_BITS-1:0] s, input logic [15:0] n);
		tok_t t;
		t = make_tok(KIND_UNKNOWN, 64'd0, 16'(s), 16'd1);
		unique case (m)
			M_IDENT: t = make_tok(KIND_IDENT, 64'd0, 16'(s), n);
			M_DEC, M_OCT, M_HEX: t = make_tok(KIND_INT, a, 16'(s), n);
			M_EQ: t.kind = KIND_ASSIGN;
			M_PLUS: t.kind = KIND_ADD;
			M_MINUS: t.kind = KIND_SUB;
			M_BANG: t.value = 64'(CH_BANG);
			M_LT: t.kind = KIND_LT;
			M_LT2: t = make_tok(KIND_SHL, 64'd0, 16'(s), 16'd2);
			M_GT: t.kind = KIND_GT;
			M_GT2: t = make_tok(KIND_SHR, 64'd0, 16'(s), 16'd2);
			M_AMP: t.kind = KIND_AND;
			M_BAR: t.kind = KIND_OR;
			default: t.value = 64'd0;
		endcase
		return t;
	endfunction

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                eot_s1;
	logic [7:0]          comment_q;
	mode_t               mode_q;
	logic [63:0]         acc_q;
	logic [15:0]         cnt_q;
	logic [POS_BITS-1:0] start_q;
	logic [POS_BITS-1:0] pos_q;
	tok_t                queue_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] head_q;
	logic [QUEUE_AW-1:0] tail_q;
	logic [QUEUE_CW-1:0] count_q;

	logic                room;
	logic                proc;
	logic                pop;
	logic [1:0]          push_n;
	mode_t               mode_d;
	logic [63:0]         acc_d;
	logic [15:0]         cnt_d;
	logic [POS_BITS-1:0] start_d;
	tok_t                r0;
	tok_t                r1;
	logic                r0_v;
	logic                r1_v;

	assign room = count_q <= QUEUE_CW'(QUEUE_DEPTH - 2);
	assign proc = valid_s1 && room;
	assign char_stall = valid_s1 && !room;
	assign token_valid = count_q != '0;
	assign pop = token_valid && !token_stall;
	assign cfg_ready = 1'b1;
	assign push_n = proc ? (2'(r0_v) + 2'(r1_v)) : 2'd0;

	assign token_kind = queue_q[head_q].kind;
	assign literal_value = queue_q[head_q].value;
	assign start_pos = queue_q[head_q].start;
	assign token_length = queue_q[head_q].length;
	assign last_of_run = queue_q[head_q].last;

	always_comb begin
		logic [7:0]  c;
		logic        consumed;
		logic        do_flush;
		logic        has_two;
		logic [7:0]  two_ch;
		kind_t       two_kind;
		logic        a_v;
		logic        b_v;
		logic        c_v;
		tok_t        a_t;
		tok_t        b_t;
		tok_t        c_t;
		logic [63:0] dig;

		c = char_s1;
		dig = 64'(c[3:0]);
		mode_d = mode_q;
		acc_d = acc_q;
		cnt_d = cnt_q;
		start_d = start_q;
		consumed = 1'b0;
		do_flush = 1'b0;
		has_two = 1'b0;
		two_ch = CH_EQ;
		two_kind = KIND_EQ;
		a_v = 1'b0;
		b_v = 1'b0;
		a_t = flush_tok(mode_q, acc_q, start_q, cnt_q);
		b_t = make_tok(KIND_UNKNOWN, 64'(c), 16'(pos_q), 16'd1);

		unique case (mode_q)
			M_IDLE: consumed = 1'b0;
			M_COMMENT: begin
				consumed = 1'b1;
				if (c == CH_NL) begin
					mode_d = M_IDLE;
				end
			end
			M_IDENT: begin
				if (is_alpha(c)) begin
					cnt_d = bump(cnt_q);
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_DEC: begin
				if (is_digit(c)) begin
					acc_d = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + dig;
					cnt_d = bump(cnt_q);
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_OCT: begin
				if (cnt_q == 16'd1 && (c == CH_LX || c == CH_UX)) begin
					mode_d = M_HEX;
					cnt_d = bump(cnt_q);
					consumed = 1'b1;
				end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
					acc_d = {acc_q[60:0], 3'b000} + dig;
					cnt_d = bump(cnt_q);
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_HEX: begin
				if (is_hex(c)) begin
					acc_d = {acc_q[59:0], 4'b0000} + dig + ((c >= CH_UA) ? 64'd9 : 64'd0);
					cnt_d = bump(cnt_q);
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_EQ: begin
				has_two = 1'b1;
				two_ch = CH_EQ;
				two_kind = KIND_EQ;
			end
			M_PLUS: begin
				has_two = 1'b1;
				two_ch = CH_PLUS;
				two_kind = KIND_INC;
			end
			M_MINUS: begin
				has_two = 1'b1;
				two_ch = CH_MINUS;
				two_kind = KIND_DEC;
			end
			M_BANG: begin
				has_two = 1'b1;
				two_ch = CH_EQ;
				two_kind = KIND_NE;
			end
			M_AMP: begin
				has_two = 1'b1;
				two_ch = CH_AMP;
				two_kind = KIND_LAND;
			end
			M_BAR: begin
				has_two = 1'b1;
				two_ch = CH_BAR;
				two_kind = KIND_LOR;
			end
			M_LT: begin
				if (c == CH_EQ) begin
					has_two = 1'b1;
					two_kind = KIND_LE;
				end else if (c == CH_LT) begin
					mode_d = M_LT2;
					cnt_d = 16'd2;
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_GT: begin
				if (c == CH_EQ) begin
					has_two = 1'b1;
					two_kind = KIND_GE;
				end else if (c == CH_GT) begin
					mode_d = M_GT2;
					cnt_d = 16'd2;
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_LT2: begin
				if (c == CH_LT) begin
					a_v = 1'b1;
					a_t = make_tok(KIND_ROL, 64'd0, 16'(start_q), 16'd3);
					mode_d = M_IDLE;
					cnt_d = 16'd0;
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			M_GT2: begin
				if (c == CH_GT) begin
					a_v = 1'b1;
					a_t = make_tok(KIND_ROR, 64'd0, 16'(start_q), 16'd3);
					mode_d = M_IDLE;
					cnt_d = 16'd0;
					consumed = 1'b1;
				end else begin
					do_flush = 1'b1;
				end
			end
			default: consumed = 1'b0;
		endcase

		if (has_two) begin
			if (c == two_ch) begin
				a_v = 1'b1;
				a_t = make_tok(two_kind, 64'd0, 16'(start_q), 16'd2);
				mode_d = M_IDLE;
				cnt_d = 16'd0;
				consumed = 1'b1;
			end else begin
				do_flush = 1'b1;
			end
		end

		if (do_flush) begin
			a_v = has_pending(mode_q);
			mode_d = M_IDLE;
			acc_d = 64'd0;
			cnt_d = 16'd0;
		end

		if (!consumed) begin
			start_d = pos_q;
			cnt_d = 16'd1;
			acc_d = 64'd0;
			if (is_alpha(c)) begin
				mode_d = M_IDENT;
			end else if (c >= CH_ONE && c <= CH_NINE) begin
				mode_d = M_DEC;
				acc_d = dig;
			end else if (c == CH_ZERO) begin
				mode_d = M_OCT;
			end else if (c == comment_q) begin
				cnt_d = 16'd0;
				mode_d = M_COMMENT;
			end else begin
				cnt_d = 16'd1;
				unique case (c) inside
					CH_SPACE, CH_TAB, CH_CR, CH_NL: cnt_d = 16'd0;
					CH_EQ: mode_d = M_EQ;
					CH_PLUS: mode_d = M_PLUS;
					CH_MINUS: mode_d = M_MINUS;
					CH_BANG: mode_d = M_BANG;
					CH_LT: mode_d = M_LT;
					CH_GT: mode_d = M_GT;
					CH_AMP: mode_d = M_AMP;
					CH_BAR: mode_d = M_BAR;
					CH_STAR: begin
						cnt_d = 16'd0;
						b_v = 1'b1;
						b_t = make_tok(KIND_MUL, 64'd0, 16'(pos_q), 16'd1);
					end
					CH_SLASH: begin
						cnt_d = 16'd0;
						b_v = 1'b1;
						b_t = make_tok(KIND_DIV, 64'd0, 16'(pos_q), 16'd1);
					end
					CH_PCT: begin
						cnt_d = 16'd0;
						b_v = 1'b1;
						b_t = make_tok(KIND_MOD, 64'd0, 16'(pos_q), 16'd1);
					end
					CH_CARET: begin
						cnt_d = 16'd0;
						b_v = 1'b1;
						b_t = make_tok(KIND_XOR, 64'd0, 16'(pos_q), 16'd1);
					end
					default: begin
						cnt_d = 16'd0;
						b_v = 1'b1;
					end
				endcase
			end
		end

		c_t = flush_tok(mode_d, acc_d, start_d, cnt_d);
		c_v = eot_s1 && has_pending(mode_d);
		if (eot_s1) begin
			mode_d = M_IDLE;
			acc_d = 64'd0;
			cnt_d = 16'd0;
		end

		r0_v = a_v || b_v || c_v;
		r0 = a_v ? a_t : (b_v ? b_t : c_t);
		r1_v = (a_v && (b_v || c_v)) || (b_v && c_v);
		r1 = (a_v && b_v) ? b_t : c_t;
		if (r1_v) begin
			r1.last = 1'b1;
		end else begin
			r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			comment_q <= COMMENT_RESET;
			mode_q <= M_IDLE;
			acc_q <= 64'd0;
			cnt_q <= 16'd0;
			start_q <= '0;
			pos_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				comment_q <= comment_char;
			end
			if (!char_stall) begin
				valid_s1 <= char_valid;
			end
			if (proc) begin
				mode_q <= mode_d;
				acc_q <= acc_d;
				cnt_q <= cnt_d;
				start_q <= start_d;
				pos_q <= eot_s1 ? '0 : pos_q + POS_BITS'(1);
				tail_q <= tail_q + QUEUE_AW'(push_n);
			end
			if (pop) begin
				head_q <= head_q + QUEUE_AW'(1);
			end
			count_q <= count_q + QUEUE_CW'(push_n) - QUEUE_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			eot_s1 <= end_of_text;
		end
		if (proc && r0_v) begin
			queue_q[tail_q] <= r0;
		end
		if (proc && r1_v) begin
			queue_q[tail_q + QUEUE_AW'(1)] <= r1;
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds directed and random source text into the source text tokenizer,
// one byte per item, and predicts every token with a behavioral lexer.
// Each token that leaves the block is compared field by field with the oldest
// prediction. Both sides idle and stall at random, and the comment byte
// changes between phases.
// ----------------------------------------------------------------------------
module testbench;
	import stt_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 600;
	localparam int RANDOM_PHASES = 5;
	localparam int SETTLE_CYCLES = 6;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_IDENT, SCAN_DEC, SCAN_OCT, SCAN_HEX, SCAN_COMMENT,
		SCAN_EQ, SCAN_PLUS, SCAN_MINUS, SCAN_BANG, SCAN_LT, SCAN_LT2,
		SCAN_GT, SCAN_GT2, SCAN_AMP, SCAN_BAR
	} scan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_code = 8'd0;
	logic        end_of_text = 1'b0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [4:0]  token_kind;
	logic [63:0] literal_value;
	logic [15:0] start_pos;
	logic [15:0] token_length;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  comment_char = COMMENT_RESET;

	scan_t       lex_mode = SCAN_IDLE;
	logic [63:0] lex_value = '0;
	logic [15:0] lex_start = '0;
	logic [15:0] lex_count = '0;
	logic [15:0] lex_pos = '0;
	logic [7:0]  comment_byte = COMMENT_RESET;

	tok_t step_tokens[$];
	tok_t predicted_tokens[$];

	int error_count = 0;
	int cycle_count = 0;
	int hold_request = 0;
	int stall_left = 0;
	bit sender_idle_on = 1'b1;
	bit receiver_idle_on = 1'b1;

	source_text_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.literal_value(literal_value),
		.start_pos    (start_pos),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.comment_char (comment_char)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_hex_digit(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic void emit_token(kind_t kind, logic [63:0] value, logic [15:0] start,
			logic [15:0] length);
		tok_t t;
		t.kind = kind;
		t.value = value;
		t.start = start;
		t.length = length;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void bump_count();
		if (lex_count != LEN_MAX)
			lex_count = lex_count + 16'd1;
	endfunction

	function automatic void flush_token();
		case (lex_mode)
			SCAN_IDENT: emit_token(KIND_IDENT, '0, lex_start, lex_count);
			SCAN_DEC, SCAN_OCT, SCAN_HEX: emit_token(KIND_INT, lex_value, lex_start, lex_count);
			SCAN_EQ: emit_token(KIND_ASSIGN, '0, lex_start, 16'd1);
			SCAN_PLUS: emit_token(KIND_ADD, '0, lex_start, 16'd1);
			SCAN_MINUS: emit_token(KIND_SUB, '0, lex_start, 16'd1);
			SCAN_BANG: emit_token(KIND_UNKNOWN, "!", lex_start, 16'd1);
			SCAN_LT: emit_token(KIND_LT, '0, lex_start, 16'd1);
			SCAN_LT2: emit_token(KIND_SHL, '0, lex_start, 16'd2);
			SCAN_GT: emit_token(KIND_GT, '0, lex_start, 16'd1);
			SCAN_GT2: emit_token(KIND_SHR, '0, lex_start, 16'd2);
			SCAN_AMP: emit_token(KIND_AND, '0, lex_start, 16'd1);
			SCAN_BAR: emit_token(KIND_OR, '0, lex_start, 16'd1);
			default: ;
		endcase
		lex_mode = SCAN_IDLE;
		lex_value = '0;
		lex_count = '0;
	endfunction

	function automatic bit continue_token(logic [7:0] c);
		logic [7:0] pair_char = 8'd0;
		kind_t pair_kind = KIND_IDENT;
		case (lex_mode)
			SCAN_IDLE: return 1'b0;
			SCAN_COMMENT: begin
				if (c == CH_LF)
					lex_mode = SCAN_IDLE;
				return 1'b1;
			end
			SCAN_IDENT: begin
				if (is_letter(c)) begin
					bump_count();
					return 1'b1;
				end
			end
			SCAN_DEC: begin
				if (c >= "0" && c <= "9") begin
					lex_value = lex_value * 64'd10 + 64'(c - "0");
					bump_count();
					return 1'b1;
				end
			end
			SCAN_OCT: begin
				if (lex_count == 16'd1 && (c == "x" || c == "X")) begin
					lex_mode = SCAN_HEX;
					bump_count();
					return 1'b1;
				end
				if (c >= "0" && c <= "7") begin
					lex_value = lex_value * 64'd8 + 64'(c - "0");
					bump_count();
					return 1'b1;
				end
			end
			SCAN_HEX: begin
				if (is_hex_digit(c)) begin
					lex_value = lex_value * 64'd16 + 64'(c & 8'h0F) + ((c >= "A") ? 64'd9 : 64'd0);
					bump_count();
					return 1'b1;
				end
			end
			SCAN_EQ: begin pair_char = "="; pair_kind = KIND_EQ; end
			SCAN_PLUS: begin pair_char = "+"; pair_kind = KIND_INC; end
			SCAN_MINUS: begin pair_char = "-"; pair_kind = KIND_DEC; end
			SCAN_BANG: begin pair_char = "="; pair_kind = KIND_NE; end
			SCAN_AMP: begin pair_char = "&"; pair_kind = KIND_LAND; end
			SCAN_BAR: begin pair_char = "|"; pair_kind = KIND_LOR; end
			SCAN_LT: begin
				if (c == "=") begin
					pair_char = "=";
					pair_kind = KIND_LE;
				end else if (c == "<") begin
					lex_mode = SCAN_LT2;
					lex_count = 16'd2;
					return 1'b1;
				end
			end
			SCAN_GT: begin
				if (c == "=") begin
					pair_char = "=";
					pair_kind = KIND_GE;
				end else if (c == ">") begin
					lex_mode = SCAN_GT2;
					lex_count = 16'd2;
					return 1'b1;
				end
			end
			SCAN_LT2: begin
				if (c == "<") begin
					emit_token(KIND_ROL, '0, lex_start, 16'd3);
					lex_mode = SCAN_IDLE;
					lex_count = '0;
					return 1'b1;
				end
			end
			SCAN_GT2: begin
				if (c == ">") begin
					emit_token(KIND_ROR, '0, lex_start, 16'd3);
					lex_mode = SCAN_IDLE;
					lex_count = '0;
					return 1'b1;
				end
			end
			default: ;
		endcase
		if (pair_char != 8'd0 && c == pair_char) begin
			emit_token(pair_kind, '0, lex_start, 16'd2);
			lex_mode = SCAN_IDLE;
			lex_count = '0;
			return 1'b1;
		end
		flush_token();
		return 1'b0;
	endfunction

	function automatic void start_token(logic [7:0] c, logic [15:0] pos);
		scan_t next_mode = SCAN_IDLE;
		lex_start = pos;
		lex_count = 16'd1;
		lex_value = '0;
		if (is_letter(c)) begin
			lex_mode = SCAN_IDENT;
		end else if (c >= "1" && c <= "9") begin
			lex_mode = SCAN_DEC;
			lex_value = 64'(c - "0");
		end else if (c == "0") begin
			lex_mode = SCAN_OCT;
		end else begin
			lex_count = '0;
			if (c == comment_byte) begin
				lex_mode = SCAN_COMMENT;
			end else begin
				case (c)
					" ", CH_TAB, CH_CR, CH_LF: ;
					"=": next_mode = SCAN_EQ;
					"+": next_mode = SCAN_PLUS;
					"-": next_mode = SCAN_MINUS;
					"!": next_mode = SCAN_BANG;
					"<": next_mode = SCAN_LT;
					">": next_mode = SCAN_GT;
					"&": next_mode = SCAN_AMP;
					"|": next_mode = SCAN_BAR;
					"*": emit_token(KIND_MUL, '0, pos, 16'd1);
					"/": emit_token(KIND_DIV, '0, pos, 16'd1);
					"%": emit_token(KIND_MOD, '0, pos, 16'd1);
					"^": emit_token(KIND_XOR, '0, pos, 16'd1);
					default: emit_token(KIND_UNKNOWN, 64'(c), pos, 16'd1);
				endcase
				if (next_mode != SCAN_IDLE) begin
					lex_mode = next_mode;
					lex_count = 16'd1;
				end
			end
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, logic eot);
		logic [15:0] pos = lex_pos;
		tok_t t;
		step_tokens.delete();
		if (!continue_token(c))
			start_token(c, pos);
		if (eot) begin
			flush_token();
			lex_pos = '0;
		end else begin
			lex_pos = pos + 16'd1;
		end
		foreach (step_tokens[i]) begin
			t = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			predicted_tokens.push_back(t);
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		tok_t want;
		if (arst_n && token_valid && !token_stall) begin
			if (predicted_tokens.size() == 0) begin
				$error("unexpected token: kind %0d, start %0d", token_kind, start_pos);
				error_count++;
			end else begin
				want = predicted_tokens.pop_front();
				check_field("token_kind", want.kind, token_kind);
				check_field("literal_value", want.value, literal_value);
				check_field("start_pos", want.start, start_pos);
				check_field("token_length", want.length, token_length);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			token_stall <= 1'b1;
			stall_left--;
		end else if (receiver_idle_on && $urandom_range(99) < 25) begin
			token_stall <= 1'b1;
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
		end else begin
			token_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic eot);
		int gap = 0;
		int r;
		char_valid <= 1'b1;
		char_code <= c;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (char_stall);
		tokenize_byte(c, eot);
		if (sender_idle_on) begin
			r = $urandom_range(99);
			if (r >= 92)
				gap = $urandom_range(40, 5);
			else if (r >= 65)
				gap = $urandom_range(3, 1);
		end
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit eot_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot_at_end && i == s.len() - 1);
	endtask

	task automatic finish_pending();
		char_valid <= 1'b0;
		@(posedge clk);
		while (predicted_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_comment_char(input logic [7:0] c);
		finish_pending();
		cfg_valid <= 1'b1;
		comment_char <= c;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		comment_byte = c;
	endtask

	task automatic test_operators();
		send_text("== ++ + -- - != ! <= <<< << < >= >>> >> > && & || | * / % ^ =", 1'b1);
	endtask

	task automatic test_literals();
		send_text("0 0x 0XfF 0778 123 18446744073709551616 ab12 x_Y9 0", 1'b1);
	endtask

	task automatic test_text_end();
		send_text("abc", 1'b1);
		send_text("#open", 1'b1);
		send_text("0x", 1'b1);
		send_text("<<", 1'b1);
		send_text("!", 1'b1);
	endtask

	task automatic test_odd_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_comment_char();
		logic [7:0] settings[$] = '{8'h00, 8'hFF, " ", "=", "a", "7", "/", "#"};
		foreach (settings[i]) begin
			write_comment_char(settings[i]);
			send_byte(settings[i], 1'b0);
			send_text("1a<", 1'b0);
			send_byte(settings[i], 1'b0);
			send_byte(CH_LF, 1'b0);
			send_text("b ", 1'b0);
			send_byte(settings[i], 1'b0);
			send_text("z*", 1'b1);
		end
	endtask

	task automatic test_backpressure();
		finish_pending();
		sender_idle_on = 1'b0;
		hold_request = 200;
		send_text("a*b+c-d/e%f^g&h|i<j>k!l*m", 1'b0);
		send_text("1*2*3*x*y*z*0x1*07*", 1'b0);
		finish_pending();
		sender_idle_on = 1'b1;
	endtask

	function automatic logic [7:0] random_letter();
		case ($urandom_range(4))
			0, 1: return 8'("a" + $urandom_range(25));
			2, 3: return 8'("A" + $urandom_range(25));
			default: return "_";
		endcase
	endfunction

	function automatic logic [7:0] random_hex_digit();
		int d = $urandom_range(15);
		if (d < 10)
			return 8'("0" + d);
		return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
	endfunction

	task automatic send_random_fragment(output int sent);
		string op_chars = "=+-!<>&|*/%^";
		logic [7:0] spaces[4] = '{" ", CH_TAB, CH_CR, CH_LF};
		logic [7:0] frag[$];
		int n;
		case ($urandom_range(9))
			0: begin
				n = $urandom_range(8, 1);
				repeat (n) frag.push_back(random_letter());
			end
			1: begin
				frag.push_back(8'("1" + $urandom_range(8)));
				n = $urandom_range(22);
				repeat (n) frag.push_back(8'("0" + $urandom_range(9)));
			end
			2: begin
				frag.push_back("0");
				n = $urandom_range(6);
				repeat (n) frag.push_back(8'("0" + $urandom_range(9)));
			end
			3: begin
				frag.push_back("0");
				frag.push_back($urandom_range(1) ? "x" : "X");
				n = $urandom_range(18);
				repeat (n) frag.push_back(random_hex_digit());
			end
			4, 5: begin
				n = $urandom_range(3, 1);
				repeat (n) frag.push_back(op_chars[$urandom_range(op_chars.len() - 1)]);
			end
			6: begin
				n = $urandom_range(3, 1);
				repeat (n) frag.push_back(spaces[$urandom_range(3)]);
			end
			7: begin
				frag.push_back(comment_byte);
				n = $urandom_range(6);
				repeat (n) frag.push_back(8'($urandom_range(126, 32)));
				frag.push_back(CH_LF);
			end
			8: frag.push_back(8'($urandom_range(255)));
			default: frag.push_back(8'($urandom_range(126, 32)));
		endcase
		foreach (frag[i])
			send_byte(frag[i], $urandom_range(39) == 0);
		sent = frag.size();
	endtask

	task automatic test_random();
		int sent;
		int phase_items;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase > 0) begin
				case ($urandom_range(3))
					0: write_comment_char("#");
					1: write_comment_char(";");
					2: write_comment_char("/");
					default: write_comment_char(8'($urandom_range(255)));
				endcase
			end
			sender_idle_on = (phase != 2);
			receiver_idle_on = (phase != 2);
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / RANDOM_PHASES) begin
				send_random_fragment(sent);
				phase_items += sent;
			end
		end
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_literals();
		test_text_end();
		test_odd_bytes();
		test_comment_char();
		test_backpressure();
		test_random();
		finish_pending();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
